[src/gcsi_pkg.sv]
// Shared types, constants and corner tables for the grid cell to simplex block.
package gcsi_pkg;

   // Grid and field sizes
   localparam int MAX_EXTENT  = 1024;
   localparam int CRD_W       = 10;
   localparam int EXT_W       = 11;
   localparam int STR_W       = 2 * EXT_W;
   localparam int PROD_W      = CRD_W + EXT_W;
   localparam int WIDE_W      = CRD_W + STR_W;
   localparam int SUM_W       = WIDE_W + 1;
   localparam int ELEM_CALC_W = SUM_W + 3;
   localparam int LINE_W      = CRD_W + 2;
   localparam int ELEM_W      = 33;
   localparam int VERT_W      = 31;
   localparam int CNT_W       = 3;
   localparam int SUB_W       = 3;
   localparam int CSR_IDX_W   = 2;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_EXTENT_I = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXTENT_J = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EXTENT_K = 2'd2;

   // Simplex counts and vertex counts
   localparam int TET_COUNT = 5;
   localparam logic [CNT_W-1:0] VCNT_BAR = 3'd2;
   localparam logic [CNT_W-1:0] VCNT_TRI = 3'd3;
   localparam logic [CNT_W-1:0] VCNT_TET = 3'd4;

   typedef enum logic [1:0] {
      KIND_BAD   = 2'd0,
      KIND_LINE  = 2'd1,
      KIND_PLANE = 2'd2,
      KIND_VOL   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ORIENT_K = 2'd0,
      ORIENT_J = 2'd1,
      ORIENT_I = 2'd2
   } orient_type;

   // One classified cell, ready to be split into simplices
   typedef struct packed {
      kind_type                kind;
      logic                    parity;
      logic [VERT_W-1:0]       base;
      logic [ELEM_W-1:0]       elem;
      logic [STR_W-1:0]        s0;
      logic [STR_W-1:0]        s1;
      logic [STR_W-1:0]        s2;
   } entry_type;

   // Tetrahedra by hexahedron corner number, for even and odd cell parity
   localparam logic [2:0] TET_EVEN [TET_COUNT][4] = '{
      '{3'd0, 3'd1, 3'd3, 3'd4}, '{3'd1, 3'd2, 3'd3, 3'd6}, '{3'd3, 3'd4, 3'd6, 3'd7},
      '{3'd1, 3'd4, 3'd5, 3'd6}, '{3'd1, 3'd3, 3'd4, 3'd6}
   };
   localparam logic [2:0] TET_ODD [TET_COUNT][4] = '{
      '{3'd0, 3'd2, 3'd3, 3'd7}, '{3'd0, 3'd1, 3'd2, 3'd5}, '{3'd2, 3'd5, 3'd6, 3'd7},
      '{3'd5, 3'd4, 3'd7, 3'd0}, '{3'd5, 3'd2, 3'd0, 3'd7}
   };

   // Simplices per cell
   function automatic logic [SUB_W-1:0] elem_count(input kind_type kind);
      case (kind)
         KIND_PLANE: elem_count = 3'd2;
         KIND_VOL:   elem_count = SUB_W'(TET_COUNT);
         default:    elem_count = 3'd1;
      endcase
   endfunction

   // Stride selector {z, y, x} from a hexahedron corner number
   function automatic logic [2:0] corner_bits(input logic [2:0] vnum);
      corner_bits = {vnum[2], vnum[1], vnum[0] ^ vnum[1]};
   endfunction

   // Stride selector of one vertex slot of one simplex
   function automatic logic [2:0] corner_code(input kind_type kind, input logic parity,
                                               input logic [SUB_W-1:0] sub,
                                               input logic [1:0] slot);
      logic [2:0] code;
      code = 3'b000;
      case (kind)
         KIND_LINE: begin
            code = (slot == 2'd1) ? 3'b001 : 3'b000;
         end
         KIND_PLANE: begin
            case (slot)
               2'd1:    code = (sub == '0) ? 3'b001 : 3'b011;
               2'd2:    code = (sub == '0) ? 3'b011 : 3'b010;
               default: code = 3'b000;
            endcase
         end
         KIND_VOL: begin
            if (sub < SUB_W'(TET_COUNT)) begin
               code = parity ? corner_bits(TET_ODD[sub][slot])
                             : corner_bits(TET_EVEN[sub][slot]);
            end
         end
         default: code = 3'b000;
      endcase
      corner_code = code;
   endfunction

endpackage

[src/gcsi_front.sv]
// Front end: configuration registers, cell classification and index arithmetic pipeline.
module gcsi_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [gcsi_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gcsi_pkg::EXT_W-1:0]       csr_data,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [gcsi_pkg::CRD_W-1:0]       req_cell_i,
   input  logic [gcsi_pkg::CRD_W-1:0]       req_cell_j,
   input  logic [gcsi_pkg::CRD_W-1:0]       req_cell_k,
   output logic                             push_valid,
   input  logic                             push_ready,
   output gcsi_pkg::entry_type              push_entry
);
   import gcsi_pkg::*;

   // Configuration registers
   logic [EXT_W-1:0] extent_i_ff, extent_j_ff, extent_k_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         extent_i_ff <= EXT_W'(1);
         extent_j_ff <= EXT_W'(1);
         extent_k_ff <= EXT_W'(1);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_EXTENT_I: extent_i_ff <= csr_data;
            CSR_EXTENT_J: extent_j_ff <= csr_data;
            CSR_EXTENT_K: extent_k_ff <= csr_data;
            default:      ;
         endcase
      end
   end

   // Clamp an extent into 1..MAX_EXTENT
   function automatic logic [EXT_W-1:0] eff_extent(input logic [EXT_W-1:0] n);
      if (n == '0) begin
         eff_extent = EXT_W'(1);
      end else if (32'(n) > 32'(MAX_EXTENT)) begin
         eff_extent = EXT_W'(MAX_EXTENT);
      end else begin
         eff_extent = n;
      end
   endfunction

   // Classify the incoming cell
   logic [EXT_W-1:0] ni, nj, nk, ni1, nj1, nk1;
   logic             one_i, one_j, one_k, outside;
   logic [1:0]       ones;
   kind_type         kind_in;
   orient_type       orient_in;

   always_comb begin
      ni    = eff_extent(extent_i_ff);
      nj    = eff_extent(extent_j_ff);
      nk    = eff_extent(extent_k_ff);
      one_i = (ni == EXT_W'(1));
      one_j = (nj == EXT_W'(1));
      one_k = (nk == EXT_W'(1));
      ni1   = one_i ? EXT_W'(1) : ni - EXT_W'(1);
      nj1   = one_j ? EXT_W'(1) : nj - EXT_W'(1);
      nk1   = one_k ? EXT_W'(1) : nk - EXT_W'(1);
      ones  = 2'(one_i) + 2'(one_j) + 2'(one_k);
      outside = ({1'b0, req_cell_i} >= ni1) || ({1'b0, req_cell_j} >= nj1) ||
                ({1'b0, req_cell_k} >= nk1);
      case (ones)
         2'd0:    kind_in = KIND_VOL;
         2'd1:    kind_in = KIND_PLANE;
         2'd2:    kind_in = KIND_LINE;
         default: kind_in = KIND_BAD;
      endcase
      if (outside) begin
         kind_in = KIND_BAD;
      end
      if (one_k) begin
         orient_in = ORIENT_K;
      end else if (one_j) begin
         orient_in = ORIENT_J;
      end else begin
         orient_in = ORIENT_I;
      end
   end

   // Stage handshakes
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic s1_ready, s2_ready, s3_ready;

   assign s3_ready  = !s3_valid_ff || push_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= req_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
      end
   end

   // Stage 1: capture cell and clamped extents
   logic [CRD_W-1:0] s1_ci_ff, s1_cj_ff, s1_ck_ff;
   logic [EXT_W-1:0] s1_ni_ff, s1_nj_ff, s1_ni1_ff, s1_nj1_ff;
   kind_type         s1_kind_ff;
   orient_type       s1_orient_ff;

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_ci_ff     <= req_cell_i;
         s1_cj_ff     <= req_cell_j;
         s1_ck_ff     <= req_cell_k;
         s1_ni_ff     <= ni;
         s1_nj_ff     <= nj;
         s1_ni1_ff    <= ni1;
         s1_nj1_ff    <= nj1;
         s1_kind_ff   <= kind_in;
         s1_orient_ff <= orient_in;
      end
   end

   // Stage 2: first products
   logic [CRD_W-1:0] e1_crd, e0_in;
   logic [EXT_W-1:0] e1_ext;

   always_comb begin
      e1_crd = s1_cj_ff;
      e1_ext = s1_ni1_ff;
      e0_in  = s1_ci_ff;
      if (s1_kind_ff == KIND_PLANE) begin
         case (s1_orient_ff)
            ORIENT_J: begin
               e1_crd = s1_ck_ff;
            end
            ORIENT_I: begin
               e1_crd = s1_ck_ff;
               e1_ext = s1_nj1_ff;
               e0_in  = s1_cj_ff;
            end
            default: ;
         endcase
      end
   end

   logic [CRD_W-1:0]  s2_ci_ff, s2_cj_ff, s2_ck_ff, s2_e0_ff;
   logic [EXT_W-1:0]  s2_ni_ff, s2_nj_ff;
   logic [PROD_W-1:0] s2_cjni_ff, s2_e1_ff;
   logic [STR_W-1:0]  s2_ninj_ff, s2_n11_ff;
   kind_type          s2_kind_ff;
   orient_type        s2_orient_ff;

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_ci_ff     <= s1_ci_ff;
         s2_cj_ff     <= s1_cj_ff;
         s2_ck_ff     <= s1_ck_ff;
         s2_e0_ff     <= e0_in;
         s2_ni_ff     <= s1_ni_ff;
         s2_nj_ff     <= s1_nj_ff;
         s2_kind_ff   <= s1_kind_ff;
         s2_orient_ff <= s1_orient_ff;
         s2_cjni_ff   <= PROD_W'(s1_cj_ff) * PROD_W'(s1_ni_ff);
         s2_e1_ff     <= PROD_W'(e1_crd) * PROD_W'(e1_ext);
         s2_ninj_ff   <= STR_W'(s1_ni_ff) * STR_W'(s1_nj_ff);
         s2_n11_ff    <= STR_W'(s1_ni1_ff) * STR_W'(s1_nj1_ff);
      end
   end

   // Stage 3: second products, partial sums and strides
   logic [STR_W-1:0] s0_in, s1_in, s2_in;

   always_comb begin
      s0_in = STR_W'(1);
      s1_in = STR_W'(s2_ni_ff);
      s2_in = s2_ninj_ff;
      case (s2_kind_ff)
         KIND_LINE: begin
            if (s2_ni_ff > EXT_W'(1)) begin
               s0_in = STR_W'(1);
            end else if (s2_nj_ff > EXT_W'(1)) begin
               s0_in = STR_W'(s2_ni_ff);
            end else begin
               s0_in = s2_ninj_ff;
            end
            s1_in = '0;
            s2_in = '0;
         end
         KIND_PLANE: begin
            s2_in = '0;
            case (s2_orient_ff)
               ORIENT_K: begin
                  s0_in = STR_W'(1);
                  s1_in = STR_W'(s2_ni_ff);
               end
               ORIENT_J: begin
                  s0_in = s2_ninj_ff;
                  s1_in = STR_W'(1);
               end
               default: begin
                  s0_in = STR_W'(s2_ni_ff);
                  s1_in = s2_ninj_ff;
               end
            endcase
         end
         default: ;
      endcase
   end

   logic [SUB_W-1:0]  unused_sub;
   logic [SUM_W-1:0]  s3_apart_ff, s3_epart_ff;
   logic [WIDE_W-1:0] s3_a2_ff, s3_e2_ff;
   logic [LINE_W-1:0] s3_line_ff;
   logic [STR_W-1:0]  s3_s0_ff, s3_s1_ff, s3_s2_ff;
   kind_type          s3_kind_ff;
   logic              s3_parity_ff;

   assign unused_sub = '0;

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         s3_kind_ff   <= s2_kind_ff;
         s3_parity_ff <= s2_ci_ff[0] ^ s2_cj_ff[0] ^ s2_ck_ff[0];
         s3_apart_ff  <= SUM_W'(1) + SUM_W'(s2_ci_ff) + SUM_W'(s2_cjni_ff);
         s3_epart_ff  <= SUM_W'(s2_e0_ff) + SUM_W'(s2_e1_ff);
         s3_a2_ff     <= WIDE_W'(s2_ck_ff) * WIDE_W'(s2_ninj_ff);
         s3_e2_ff     <= WIDE_W'(s2_ck_ff) * WIDE_W'(s2_n11_ff);
         s3_line_ff   <= LINE_W'(s2_ci_ff) + LINE_W'(s2_cj_ff) + LINE_W'(s2_ck_ff);
         s3_s0_ff     <= s0_in;
         s3_s1_ff     <= s1_in;
         s3_s2_ff     <= s2_in;
      end
   end

   // Finish base vertex and first element index
   logic [SUM_W-1:0]       a_sum, e_sum;
   logic [ELEM_CALC_W-1:0] elem_calc;

   always_comb begin
      a_sum = s3_apart_ff + SUM_W'(s3_a2_ff);
      e_sum = s3_epart_ff + ((s3_kind_ff == KIND_VOL) ? SUM_W'(s3_e2_ff) : '0);
      case (s3_kind_ff)
         KIND_VOL:   elem_calc = (ELEM_CALC_W'(e_sum) << 2) + ELEM_CALC_W'(e_sum);
         KIND_PLANE: elem_calc = ELEM_CALC_W'(e_sum) << 1;
         KIND_LINE:  elem_calc = ELEM_CALC_W'(s3_line_ff);
         default:    elem_calc = ELEM_CALC_W'(unused_sub);
      endcase
      push_entry.kind   = s3_kind_ff;
      push_entry.parity = s3_parity_ff;
      push_entry.base   = a_sum[VERT_W-1:0];
      push_entry.elem   = elem_calc[ELEM_W-1:0];
      push_entry.s0     = s3_s0_ff;
      push_entry.s1     = s3_s1_ff;
      push_entry.s2     = s3_s2_ff;
   end

   assign push_valid = s3_valid_ff;

endmodule

[src/gcsi_queue.sv]
// Short queue of classified cells between the front and back ends.
module gcsi_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  gcsi_pkg::entry_type in_entry,
   output logic                out_valid,
   input  logic                out_ready,
   output gcsi_pkg::entry_type out_entry
);
   import gcsi_pkg::*;

   entry_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push, pop;

   assign in_ready  = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         count_ff <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_entry;
      end
   end

endmodule

[src/gcsi_back.sv]
// Back end: expands one classified cell into its simplices on the result channel.
module gcsi_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   output logic                              q_ready,
   input  gcsi_pkg::entry_type               q_entry,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [gcsi_pkg::ELEM_W-1:0]       rsp_element_index,
   output logic [gcsi_pkg::VERT_W-1:0]       rsp_vertex_a,
   output logic [gcsi_pkg::VERT_W-1:0]       rsp_vertex_b,
   output logic [gcsi_pkg::VERT_W-1:0]       rsp_vertex_c,
   output logic [gcsi_pkg::VERT_W-1:0]       rsp_vertex_d,
   output logic [gcsi_pkg::CNT_W-1:0]        rsp_vertex_count,
   output logic                              rsp_last_of_cell,
   output logic                              rsp_bad_cell
);
   import gcsi_pkg::*;

   logic [SUB_W-1:0]  sub_ff;
   logic              rsp_valid_ff;
   logic              load, sub_last;
   logic [2:0]        code [4];
   logic [VERT_W-1:0] vert [4];
   logic [ELEM_W-1:0] elem_in;
   logic [CNT_W-1:0]  vcnt_in;
   logic              bad_in;

   assign sub_last = (sub_ff == elem_count(q_entry.kind) - SUB_W'(1));
   assign load     = q_valid && (!rsp_valid_ff || rsp_ready);
   assign q_ready  = load && sub_last;

   // Build vertices of the current simplex from the base and strides
   always_comb begin
      for (int s = 0; s < 4; s++) begin
         code[s] = corner_code(q_entry.kind, q_entry.parity, sub_ff, 2'(s));
         vert[s] = q_entry.base + (code[s][0] ? VERT_W'(q_entry.s0) : '0)
                                + (code[s][1] ? VERT_W'(q_entry.s1) : '0)
                                + (code[s][2] ? VERT_W'(q_entry.s2) : '0);
      end
      bad_in  = (q_entry.kind == KIND_BAD);
      elem_in = bad_in ? '0 : q_entry.elem + ELEM_W'(sub_ff);
      case (q_entry.kind)
         KIND_LINE:  vcnt_in = VCNT_BAR;
         KIND_PLANE: vcnt_in = VCNT_TRI;
         KIND_VOL:   vcnt_in = VCNT_TET;
         default:    vcnt_in = '0;
      endcase
   end

   // Step through the simplices of the head entry
   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            sub_ff <= sub_last ? '0 : sub_ff + SUB_W'(1);
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Hold the output transaction
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_element_index <= elem_in;
         rsp_vertex_a      <= bad_in ? '0 : vert[0];
         rsp_vertex_b      <= bad_in ? '0 : vert[1];
         rsp_vertex_c      <= (q_entry.kind == KIND_PLANE || q_entry.kind == KIND_VOL)
                              ? vert[2] : '0;
         rsp_vertex_d      <= (q_entry.kind == KIND_VOL) ? vert[3] : '0;
         rsp_vertex_count  <= vcnt_in;
         rsp_last_of_cell  <= sub_last;
         rsp_bad_cell      <= bad_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // Mid-cell position requires the cell to still be at the queue head
   assert property (@(posedge clock) disable iff (reset) sub_ff != '0 |-> q_valid)
      else $error("simplex counter advanced without a queued cell");

   // Counter stays within a volume cell
   assert property (@(posedge clock) disable iff (reset) sub_ff < SUB_W'(TET_COUNT))
      else $error("simplex counter out of range");

   // A bad cell is a single, empty, final transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_bad_cell |-> rsp_last_of_cell && rsp_vertex_count == '0)
      else $error("bad cell transaction malformed");

endmodule

[src/grid_cell_to_simplex_indices.sv]
// Top level: splits structured grid cells into bars, triangles or tetrahedra.
//
// Usage:
//  - csr_*: write extent_i (index 0), extent_j (1), extent_k (2) while idle;
//    csr_ready is always high and other indexes are ignored.
//  - req_*: one cell coordinate per transaction; accepted when req_valid and
//    req_ready are both high, one cell per cycle while the queue has room.
//  - rsp_*: one simplex per transaction with its element index and vertices;
//    rsp_last_of_cell marks the final simplex of a cell, rsp_bad_cell a cell
//    outside the grid (single transaction, all other fields zero).
// Path: the first simplex of an accepted cell passes through three arithmetic
// stages, the queue and the output register before it is valid.
// Throughput: the result port issues one simplex per cycle while rsp_ready is
// high, so a cell yields one on a line, two on a plane and five in a volume;
// the front end runs ahead by up to the queue depth plus its three stages.
// Reset: extents return to 1, the pipeline and queue empty; no clearing pass.
// Stall: while rsp_ready is low the output holds, the queue fills, and then
// req_ready drops until the result side drains.
module grid_cell_to_simplex_indices (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [gcsi_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gcsi_pkg::EXT_W-1:0]        csr_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [gcsi_pkg::CRD_W-1:0]        req_cell_i,
   input  logic [gcsi_pkg::CRD_W-1:0]        req_cell_j,
   input  logic [gcsi_pkg::CRD_W-1:0]        req_cell_k,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [gcsi_pkg::ELEM_W-1:0]       rsp_element_index,
   output logic [gcsi_pkg::VERT_W-1:0]       rsp_vertex_a,
   output logic [gcsi_pkg::VERT_W-1:0]       rsp_vertex_b,
   output logic [gcsi_pkg::VERT_W-1:0]       rsp_vertex_c,
   output logic [gcsi_pkg::VERT_W-1:0]       rsp_vertex_d,
   output logic [gcsi_pkg::CNT_W-1:0]        rsp_vertex_count,
   output logic                              rsp_last_of_cell,
   output logic                              rsp_bad_cell
);
   import gcsi_pkg::*;

   logic      push_valid, push_ready, q_valid, q_ready;
   entry_type push_entry, q_entry;

   gcsi_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_cell_i (req_cell_i),
      .req_cell_j (req_cell_j),
      .req_cell_k (req_cell_k),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   gcsi_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_entry  (push_entry),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_entry (q_entry)
   );

   gcsi_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_ready           (q_ready),
      .q_entry           (q_entry),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_element_index (rsp_element_index),
      .rsp_vertex_a      (rsp_vertex_a),
      .rsp_vertex_b      (rsp_vertex_b),
      .rsp_vertex_c      (rsp_vertex_c),
      .rsp_vertex_d      (rsp_vertex_d),
      .rsp_vertex_count  (rsp_vertex_count),
      .rsp_last_of_cell  (rsp_last_of_cell),
      .rsp_bad_cell      (rsp_bad_cell)
   );

endmodule
